/* rtl/lpm_pkg.sv */
package lpm_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int PORT_COUNT_DEF  = 4;

	localparam int ADDR_W  = 32;
	localparam int INDEX_W = 4;
	localparam int PORT_W  = 2;

	// slot numbers carried by items reach 15 at most
	localparam int INDEX_SPAN = 1 << INDEX_W;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
	} route_entry_t;

	// compare unit control, in the cycle after the table read was issued
	typedef struct packed {
		logic               clear;
		logic               en;
		logic [INDEX_W-1:0] idx;
	} cmp_ctrl_t;

	typedef struct packed {
		logic               have;
		logic [ADDR_W-1:0]  mask;
		logic [ADDR_W-1:0]  gateway;
		logic [PORT_W-1:0]  port;
		logic [INDEX_W-1:0] idx;
	} best_route_t;

endpackage

/* rtl/lpm_table.sv */
module lpm_table
	import lpm_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [INDEX_W-1:0]     wr_index,
	input  logic                   wr_valid,
	input  route_entry_t           wr_entry,
	input  logic [$clog2((TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN)-1:0] rd_addr,
	output route_entry_t           rd_entry,
	output logic                   rd_valid
);

	localparam int SLOTS = (TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN;
	localparam int IW    = $clog2(SLOTS);

	route_entry_t       mem [SLOTS];
	logic [SLOTS-1:0]   valid_q;
	logic               in_range;
	logic [IW-1:0]      wr_addr;

	assign in_range = 32'(wr_index) < 32'(TABLE_DEPTH);
	assign wr_addr  = wr_index[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en && in_range) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_entry <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en && in_range) begin
				valid_q[wr_addr] <= wr_valid;
			end
			rd_valid <= valid_q[rd_addr];
		end
	end

endmodule

/* rtl/lpm_match.sv */
module lpm_match
	import lpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmp_ctrl_t         ctrl,
	input  logic [ADDR_W-1:0] addr,
	input  route_entry_t      entry,
	input  logic              entry_valid,
	output best_route_t       best
);

	best_route_t best_q;
	logic        hit;
	logic        take;

	assign hit  = entry_valid && (((addr ^ entry.dest) & entry.mask) == '0);
	// strict compare keeps the lower slot on equal masks
	assign take = ctrl.en && hit && (!best_q.have || (entry.mask > best_q.mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctrl.clear) begin
			best_q.have <= 1'b0;
		end else if (take) begin
			best_q.have    <= 1'b1;
			best_q.mask    <= entry.mask;
			best_q.gateway <= entry.gateway;
			best_q.port    <= entry.port;
			best_q.idx     <= ctrl.idx;
		end
	end

	assign best = best_q;

endmodule

/* rtl/longest_prefix_route_lookup_top.sv */
// channel  | dir | tdata (low bit up)                                 | tuser
// s_axis   | in  | entry_index, entry_valid, entry_dest, entry_mask,  | func
//          |     | entry_gateway, entry_port, lookup_addr             |
// m_axis   | out | found, next_hop, out_port, hit_index               | -
//
// Write item: written to the table on acceptance, no result.
// Lookup: min(TABLE_DEPTH,16) table reads, one masked compare per cycle in the
// shared compare unit; not ready during the walk.
// The result sits in an output register; a new item is taken while it waits.
// Reset clears all valid bits at once.
module longest_prefix_route_lookup_top
	import lpm_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [3:0] entry_index, [4] entry_valid, [36:5] entry_dest, [68:37] entry_mask,
	// [100:69] entry_gateway, [102:101] entry_port, [134:103] lookup_addr, [135] zero
	input  logic [135:0] s_axis_tdata,
	// [0] func
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] found, [32:1] next_hop, [34:33] out_port, [38:35] hit_index, [39] zero
	output logic [39:0]  m_axis_tdata
);

	localparam int SLOTS = (TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN;
	localparam int IW    = $clog2(SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_LAST = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [IW-1:0]      rd_cnt_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               en_s1;
	logic [IW-1:0]      idx_s1;
	logic               out_valid_q;
	logic [39:0]        out_data_q;

	logic               in_acc;
	logic               lookup_acc;
	logic               wr_en;
	logic               out_load;
	route_entry_t       wr_entry;
	route_entry_t       rd_entry;
	logic               rd_valid;
	cmp_ctrl_t          ctrl;
	best_route_t        best;
	logic [39:0]        result;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign lookup_acc    = in_acc && (s_axis_tuser == FUNC_LOOKUP);
	assign wr_en         = in_acc && (s_axis_tuser == FUNC_WRITE);
	assign out_load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	assign wr_entry.dest    = s_axis_tdata[36:5];
	assign wr_entry.mask    = s_axis_tdata[68:37];
	assign wr_entry.gateway = s_axis_tdata[100:69];
	assign wr_entry.port    = s_axis_tdata[102:101];

	lpm_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (s_axis_tdata[3:0]),
		.wr_valid (s_axis_tdata[4]),
		.wr_entry (wr_entry),
		.rd_addr  (rd_cnt_q),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid)
	);

	assign ctrl.clear = lookup_acc;
	assign ctrl.en    = en_s1;
	assign ctrl.idx   = INDEX_W'(idx_s1);

	lpm_match u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.addr        (addr_q),
		.entry       (rd_entry),
		.entry_valid (rd_valid),
		.best        (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			en_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			en_s1 <= (state_q == ST_WALK);
			unique case (state_q)
				ST_IDLE: begin
					if (lookup_acc) begin
						rd_cnt_q <= '0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == IW'(SLOTS - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// last compare lands this cycle
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_acc) begin
			addr_q <= s_axis_tdata[134:103];
		end
		idx_s1 <= rd_cnt_q;
		if (out_load) begin
			out_data_q <= result;
		end
	end

	// no route reports all-zero fields
	always_comb begin
		result = '0;
		if (best.have) begin
			result[0]     = 1'b1;
			result[32:1]  = best.gateway;
			result[34:33] = best.port;
			result[38:35] = best.idx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
	import lpm_pkg::*;

	localparam int SLOTS       = TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 540;
	localparam int DRAIN_WAIT  = 2 * SLOTS + 8;

	typedef struct packed {
		logic               func;
		logic [INDEX_W-1:0] slot;
		logic               enable;
		logic [ADDR_W-1:0]  dest;
		logic [ADDR_W-1:0]  mask;
		logic [ADDR_W-1:0]  gateway;
		logic [PORT_W-1:0]  port;
		logic [ADDR_W-1:0]  addr;
	} route_req_t;

	typedef struct packed {
		logic               found;
		logic [ADDR_W-1:0]  next_hop;
		logic [PORT_W-1:0]  out_port;
		logic [INDEX_W-1:0] hit_index;
	} route_res_t;

	typedef struct {
		route_req_t req;
		bit         known;
		route_res_t res;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [39:0]  m_axis_tdata;

	// predictor copy of the routing table
	route_entry_t route_tab [SLOTS];
	bit           route_on  [SLOTS];

	route_res_t   route_expect [$];
	dir_row_t     dir_rows [$];
	logic [ADDR_W-1:0] net_pool [6];

	int src_idle = 0;
	int snk_idle = 0;
	int err_count = 0;
	int cycle_count = 0;

	longest_prefix_route_lookup_top #(
		.TABLE_DEPTH(SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic route_res_t route_lookup(input logic [ADDR_W-1:0] addr);
		route_res_t best;
		logic [ADDR_W-1:0] best_mask;
		best = '0;
		best_mask = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (route_on[i] && ((addr & route_tab[i].mask) == (route_tab[i].dest & route_tab[i].mask))
					&& (!best.found || route_tab[i].mask > best_mask)) begin
				best.found     = 1'b1;
				best.next_hop  = route_tab[i].gateway;
				best.out_port  = route_tab[i].port;
				best.hit_index = INDEX_W'(i);
				best_mask      = route_tab[i].mask;
			end
		end
		return best;
	endfunction

	function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
		// len 0 shifts everything out: default route
		return {ADDR_W{1'b1}} << (ADDR_W - len);
	endfunction

	task automatic wr_row(input int slot, input logic enable, input logic [31:0] dest,
			input logic [31:0] mask, input logic [31:0] gateway, input logic [1:0] port);
		dir_row_t row;
		row.req = '0;
		row.req.func = FUNC_WRITE;
		row.req.slot = INDEX_W'(slot);
		row.req.enable = enable;
		row.req.dest = dest;
		row.req.mask = mask;
		row.req.gateway = gateway;
		row.req.port = port;
		row.known = 1'b0;
		row.res = '0;
		dir_rows.push_back(row);
	endtask

	task automatic lk_row(input logic [31:0] addr, input bit known, input logic found,
			input logic [31:0] next_hop, input logic [1:0] out_port, input int hit_index);
		dir_row_t row;
		row.req = '0;
		row.req.func = FUNC_LOOKUP;
		row.req.addr = addr;
		row.known = known;
		row.res = '{found, next_hop, out_port, INDEX_W'(hit_index)};
		dir_rows.push_back(row);
	endtask

	// drive one item, wait for the handshake, then update the predictor
	task automatic send_req(input route_req_t r, input bit known, input route_res_t res);
		if (r.func == FUNC_LOOKUP) begin
			r.slot    = INDEX_W'($urandom_range(0, INDEX_SPAN - 1));
			r.enable  = 1'($urandom_range(0, 1));
			r.dest    = $urandom;
			r.mask    = $urandom;
			r.gateway = $urandom;
			r.port    = PORT_W'($urandom_range(0, 3));
		end else begin
			r.addr = $urandom;
		end
		if ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.func;
		s_axis_tdata  <= {1'b0, r.addr, r.port, r.gateway, r.mask, r.dest, r.enable, r.slot};
		do @(posedge clk); while (!s_axis_tready);
		if (r.func == FUNC_WRITE) begin
			if (int'(r.slot) < SLOTS) begin
				route_on[r.slot]  = r.enable;
				route_tab[r.slot] = '{r.dest, r.mask, r.gateway, r.port};
			end
		end else begin
			route_expect.push_back(known ? res : route_lookup(r.addr));
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (route_expect.size() != 0);
	endtask

	function automatic route_req_t random_req();
		route_req_t r;
		int sel;
		int s;
		r = '0;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			r.func    = FUNC_WRITE;
			r.slot    = INDEX_W'($urandom_range(0, INDEX_SPAN - 1));
			r.enable  = ($urandom_range(0, 99) < 85);
			r.dest    = net_pool[$urandom_range(0, 5)] ^ ($urandom >> $urandom_range(8, 32));
			if ($urandom_range(0, 99) < 15)
				r.mask = $urandom;
			else if ($urandom_range(0, 99) < 10)
				r.mask = prefix_mask($urandom_range(0, 32));
			else
				r.mask = prefix_mask($urandom_range(8, 32));
			r.gateway = $urandom;
			r.port    = PORT_W'($urandom_range(0, 3));
		end else begin
			r.func = FUNC_LOOKUP;
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				// land inside some slot's prefix
				s = $urandom_range(0, SLOTS - 1);
				r.addr = (route_tab[s].dest & route_tab[s].mask) | ($urandom & ~route_tab[s].mask);
			end else if (sel < 85) begin
				r.addr = net_pool[$urandom_range(0, 5)] ^ ($urandom >> $urandom_range(4, 32));
			end else begin
				r.addr = $urandom;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if ($urandom_range(0, 99) < snk_idle)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin : result_check
		route_res_t want;
		route_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			// tdata carries found in bit 0, hit_index on top
			got = {m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[34:33],
				m_axis_tdata[38:35]};
			if (route_expect.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				err_count++;
			end else begin
				want = route_expect.pop_front();
				if (got.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, got.found);
					err_count++;
				end
				if (got.next_hop !== want.next_hop) begin
					$error("next_hop: expected %h, got %h", want.next_hop, got.next_hop);
					err_count++;
				end
				if (got.out_port !== want.out_port) begin
					$error("out_port: expected %0d, got %0d", want.out_port, got.out_port);
					err_count++;
				end
				if (got.hit_index !== want.hit_index) begin
					$error("hit_index: expected %0d, got %0d", want.hit_index, got.hit_index);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			route_on[i]  = 1'b0;
			route_tab[i] = '0;
		end

		// empty table, then default route in the last slot
		lk_row(32'h0000_0000, 1, 1'b0, 32'h0, 2'd0, 0);
		lk_row(32'hFFFF_FFFF, 1, 1'b0, 32'h0, 2'd0, 0);
		wr_row(15, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 2'd3);
		lk_row(32'h1234_5678, 1, 1'b1, 32'hFFFF_FFFF, 2'd3, 15);
		// host route, all-ones extremes
		wr_row(0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0A00_0001, 2'd0);
		lk_row(32'hFFFF_FFFF, 1, 1'b1, 32'h0A00_0001, 2'd0, 0);
		lk_row(32'hFFFF_FFFE, 1, 1'b1, 32'hFFFF_FFFF, 2'd3, 15);
		// two /24 with the same masked network: lower slot wins the tie
		wr_row(5, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 2'd2);
		wr_row(3, 1'b1, 32'hC0A8_01FF, 32'hFFFF_FF00, 32'h0B0B_0B0B, 2'd1);
		lk_row(32'hC0A8_0177, 1, 1'b1, 32'h0B0B_0B0B, 2'd1, 3);
		// longer prefix beats the /24
		wr_row(7, 1'b1, 32'hC0A8_0180, 32'hFFFF_FF80, 32'h0102_0304, 2'd3);
		lk_row(32'hC0A8_01F0, 1, 1'b1, 32'h0102_0304, 2'd3, 7);
		lk_row(32'hC0A8_0110, 1, 1'b1, 32'h0B0B_0B0B, 2'd1, 3);
		// drop slot 3, slot 5 takes over
		wr_row(3, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1357_9BDF, 2'd2);
		lk_row(32'hC0A8_0110, 1, 1'b1, 32'hC0A8_0101, 2'd2, 5);
		// non-contiguous mask ranked by value
		wr_row(9, 1'b1, 32'hA0B0_C0D0, 32'hF0F0_F0F0, 32'h55AA_55AA, 2'd1);
		lk_row(32'hA5B5_C5D5, 0, 1'b0, 32'h0, 2'd0, 0);
		lk_row(32'hC0A8_01A5, 0, 1'b0, 32'h0, 2'd0, 0);
		// remove default and host route: no match anywhere
		wr_row(15, 1'b0, 32'h0, 32'h0, 32'h0, 2'd0);
		wr_row(0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
		lk_row(32'h1234_5678, 1, 1'b0, 32'h0, 2'd0, 0);
		lk_row(32'hFFFF_FFFF, 1, 1'b0, 32'h0, 2'd0, 0);

		src_idle = 28;
		snk_idle = 81;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);

		for (int i = 0; i < 6; i++)
			net_pool[i] = $urandom;

		for (int p = 0; p < 3; p++) begin
			// hold off until the block has delivered everything
			drain_results();
			src_idle = (p == 0) ? 28 : (p == 1) ? 81 : 0;
			snk_idle = (p == 0) ? 81 : (p == 1) ? 28 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_req(random_req(), 1'b0, '0);
		end

		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
